### rtl/alds_pkg.sv
package alds_pkg;

  localparam logic [7:0] START_BYTE    = 8'hBB;
  localparam logic [7:0] FRM_ECHO      = 8'hC0;
  localparam logic [7:0] FRM_SPECTRUM  = 8'hC2;
  localparam logic [7:0] FRM_STATUS    = 8'hFC;

  localparam logic [15:0] TIMEOUT_RESET   = 16'd4000;
  localparam logic [10:0] KEEPALIVE_RESET = 11'd2000;

  localparam logic [3:0] C_RX      = 4'd0;
  localparam logic [3:0] C_TICK    = 4'd1;
  localparam logic [3:0] C_OPEN    = 4'd2;
  localparam logic [3:0] C_CLOSE   = 4'd3;
  localparam logic [3:0] C_ERROR   = 4'd4;
  localparam logic [3:0] C_START   = 4'd5;
  localparam logic [3:0] C_STOP    = 4'd6;
  localparam logic [3:0] C_BW      = 4'd7;
  localparam logic [3:0] C_RANGE   = 4'd8;
  localparam logic [3:0] C_ALT     = 4'd9;

  localparam logic [2:0] K_BYTE      = 3'd0;
  localparam logic [2:0] K_DELIVERED = 3'd1;
  localparam logic [2:0] K_STALE     = 3'd2;
  localparam logic [2:0] K_ECHO      = 3'd3;
  localparam logic [2:0] K_REQUEST   = 3'd4;
  localparam logic [2:0] K_CONNECTED = 3'd5;
  localparam logic [2:0] K_DISCONN   = 3'd6;
  localparam logic [2:0] K_BADLEN    = 3'd7;

  localparam logic [1:0] CAUSE_USER    = 2'd0;
  localparam logic [1:0] CAUSE_TIMEOUT = 2'd1;
  localparam logic [1:0] CAUSE_XPORT   = 2'd2;

  localparam logic [0:0] REG_TIMEOUT   = 1'd0;
  localparam logic [0:0] REG_KEEPALIVE = 1'd1;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data_byte;
    logic [1:0] range_select;
    logic [1:0] request_bandwidth;
    logic [1:0] drop_cause;
  } res_t;

  // one queue entry: up to two results of one transaction
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } batch_t;

endpackage

### rtl/alds_if.sv
interface alds_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] cmd;
  logic [7:0] rx_byte;
  logic [1:0] bandwidth;
  logic       alt_on;
  modport source (output valid, cmd, rx_byte, bandwidth, alt_on, input ready);
  modport sink   (input valid, cmd, rx_byte, bandwidth, alt_on, output ready);
endinterface

interface alds_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] data_byte;
  logic [1:0] range_select;
  logic [1:0] request_bandwidth;
  logic [1:0] drop_cause;
  logic       last;
  modport source (output valid, kind, data_byte, range_select, request_bandwidth,
                  drop_cause, last, input ready);
  modport sink   (input valid, kind, data_byte, range_select, request_bandwidth,
                  drop_cause, last, output ready);
endinterface

interface alds_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/analyzer_link_deframer_session_unit.sv
// channel | dir | payload
// in_     | in  | cmd, rx_byte, bandwidth, alt_on
// out_    | out | kind, data_byte, range_select, request_bandwidth, drop_cause, last
// cfg_    | in  | index (0 timeout, 1 keep-alive), data
// One transaction per cycle on the input; ready drops only when the queue is full.
// The front deframer and session logic finish each in that cycle and push 0..2
// results into a two-entry queue, which drains one result per cycle while out_ready.
// Synchronous active-low reset: hunting, link closed, registers to 4000/2000.
module analyzer_link_deframer_session_unit
  import alds_pkg::*;
#(
  parameter int MAX_STALE = 8
) (
  input logic clk,
  input logic rst_n,
  alds_in_if.sink     in_ch,
  alds_out_if.source  out_ch,
  alds_cfg_if.sink    cfg_ch
);

  logic [15:0] tmo_r;
  logic [10:0] ka_r;
  batch_t      batch;
  logic        full, fire;

  assign in_ch.ready  = !full;
  assign fire         = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tmo_r <= TIMEOUT_RESET;
      ka_r  <= KEEPALIVE_RESET;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == REG_TIMEOUT) tmo_r <= cfg_ch.data;
      else ka_r <= cfg_ch.data[10:0];
    end
  end

  alds_front #(.MAX_STALE(MAX_STALE)) u_front (
    .clk, .rst_n, .fire,
    .cmd(in_ch.cmd), .rx_byte(in_ch.rx_byte), .bandwidth(in_ch.bandwidth),
    .alt_on(in_ch.alt_on), .timeout_ticks(tmo_r), .keepalive_ticks(ka_r), .batch
  );

  // silent transactions never take a queue slot
  alds_back u_back (
    .clk, .rst_n, .push(fire && batch.n != 2'd0), .batch, .full, .out_ch
  );

endmodule

### rtl/alds_front.sv
module alds_front
  import alds_pkg::*;
#(
  parameter int MAX_STALE = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  logic [3:0]  cmd,
  input  logic [7:0]  rx_byte,
  input  logic [1:0]  bandwidth,
  input  logic        alt_on,
  input  logic [15:0] timeout_ticks,
  input  logic [10:0] keepalive_ticks,
  output batch_t      batch
);

  localparam logic [3:0] MAXS = 4'(MAX_STALE);

  logic [2:0]  phase_r, phase_nxt;
  logic [7:0]  fcmd_r, fcmd_nxt;
  logic [15:0] flen_r, flen_nxt;
  logic [16:0] left_r, left_nxt;
  logic open_r, open_nxt, conn_r, conn_nxt, await_r, await_nxt;
  logic strm_r, strm_nxt, req_r, req_nxt, alt_r, alt_nxt, wide_r, wide_nxt;
  logic tv_r, tv_nxt;
  logic [3:0]  stale_r, stale_nxt;
  logic [1:0]  bw_r, bw_nxt;
  logic [15:0] rel_r, rel_nxt;
  logic [10:0] ka_r, ka_nxt;

  localparam logic [2:0] PH_HUNT = 3'd0, PH_CMD = 3'd1, PH_LO = 3'd2, PH_HI = 3'd3,
                         PH_BODY = 3'd4;

  always_comb begin
    res_t e;
    logic [16:0] lft;
    logic [10:0] ka1;
    phase_nxt = phase_r; fcmd_nxt = fcmd_r; flen_nxt = flen_r; left_nxt = left_r;
    open_nxt = open_r; conn_nxt = conn_r; await_nxt = await_r; strm_nxt = strm_r;
    req_nxt = req_r; alt_nxt = alt_r; wide_nxt = wide_r; tv_nxt = tv_r;
    stale_nxt = stale_r; bw_nxt = bw_r; rel_nxt = rel_r; ka_nxt = ka_r;
    batch = '0;
    e = '0;
    lft = '0;
    ka1 = '0;
    case (cmd)
      C_RX: begin
        if (open_r) begin
          case (phase_r)
            PH_HUNT: if (rx_byte == START_BYTE) phase_nxt = PH_CMD;
            PH_CMD: begin
              fcmd_nxt = rx_byte; phase_nxt = PH_LO;
            end
            PH_LO: begin
              flen_nxt = {8'd0, rx_byte}; phase_nxt = PH_HI;
            end
            PH_HI: begin
              flen_nxt = {rx_byte, flen_r[7:0]};
              left_nxt = {1'b0, rx_byte, flen_r[7:0]} + 17'd2;
              phase_nxt = PH_BODY;
            end
            default: begin
              if (left_r > 17'd2 && fcmd_r == FRM_SPECTRUM) begin
                e = '0; e.kind = K_BYTE; e.data_byte = rx_byte;
                batch.r0 = e; batch.n = 2'd1;
              end
              lft = (left_r != 17'd0) ? left_r - 17'd1 : left_r;
              left_nxt = lft;
              if (lft == 17'd0) begin
                phase_nxt = PH_HUNT;
                if (fcmd_r == FRM_SPECTRUM) begin
                  if (flen_r[2:0] != 3'd0) begin
                    // streaming ends here, so the echo always follows
                    e = '0; e.kind = K_BADLEN;
                    if (batch.n == 2'd0) begin
                      batch.r0 = e; batch.n = 2'd1;
                      e = '0; e.kind = K_ECHO; batch.r1 = e; batch.n = 2'd2;
                    end else begin
                      batch.r1 = e; batch.n = 2'd2;
                    end
                    strm_nxt = 1'b0; req_nxt = 1'b0; ka_nxt = '0;
                  end else begin
                    tv_nxt = 1'b1; rel_nxt = '0; req_nxt = 1'b0;
                    e = '0;
                    e.kind = (stale_r != 4'd0 || !strm_r) ? K_STALE : K_DELIVERED;
                    if (stale_r != 4'd0) stale_nxt = stale_r - 4'd1;
                    if (batch.n == 2'd0) begin
                      batch.r0 = e; batch.n = 2'd1;
                      if (strm_r) begin
                        e = '0; e.kind = K_REQUEST; e.request_bandwidth = bw_r;
                        if (alt_r) begin
                          e.range_select = wide_r ? 2'd2 : 2'd1;
                          wide_nxt = !wide_r;
                        end
                        batch.r1 = e; batch.n = 2'd2; req_nxt = 1'b1;
                      end
                    end else begin
                      batch.r1 = e; batch.n = 2'd2;
                    end
                  end
                end else if (fcmd_r != FRM_STATUS) begin
                  tv_nxt = 1'b1; rel_nxt = '0;
                  if (fcmd_r == FRM_ECHO && !conn_r) begin
                    conn_nxt = 1'b1; await_nxt = 1'b0;
                    e = '0; e.kind = K_CONNECTED;
                    if (batch.n == 2'd0) begin
                      batch.r0 = e; batch.n = 2'd1;
                    end else begin
                      batch.r1 = e; batch.n = 2'd2;
                    end
                  end
                end
              end
            end
          endcase
        end
      end
      C_TICK: begin
        if (open_r && tv_r && rel_r != 16'hFFFF) rel_nxt = rel_r + 16'd1;
        if (open_r && tv_r && rel_nxt > timeout_ticks && (conn_r || await_r)) begin
          conn_nxt = 1'b0; await_nxt = 1'b0; tv_nxt = 1'b0; rel_nxt = '0;
          phase_nxt = PH_HUNT; left_nxt = '0; strm_nxt = 1'b0; req_nxt = 1'b0;
          stale_nxt = '0; ka_nxt = '0; open_nxt = 1'b0;
          e = '0; e.kind = K_DISCONN; e.drop_cause = CAUSE_TIMEOUT;
          batch.r0 = e; batch.n = 2'd1;
        end else if (open_r && !strm_r) begin
          ka1 = ka_r + 11'd1;
          ka_nxt = ka1;
          if (ka1 >= keepalive_ticks) begin
            ka_nxt = '0;
            e = '0; e.kind = K_ECHO; batch.r0 = e; batch.n = 2'd1;
          end
        end
      end
      C_OPEN: begin
        if (!open_r) begin
          open_nxt = 1'b1; conn_nxt = 1'b0; await_nxt = 1'b1; phase_nxt = PH_HUNT;
          left_nxt = '0; tv_nxt = 1'b1; rel_nxt = '0; ka_nxt = '0;
          if (!strm_r) begin
            e = '0; e.kind = K_ECHO; batch.r0 = e; batch.n = 2'd1;
          end
        end
      end
      C_CLOSE, C_ERROR: begin
        conn_nxt = 1'b0; await_nxt = 1'b0; tv_nxt = 1'b0; rel_nxt = '0;
        phase_nxt = PH_HUNT; left_nxt = '0; strm_nxt = 1'b0; req_nxt = 1'b0;
        if (cmd == C_ERROR) stale_nxt = '0;
        ka_nxt = '0; open_nxt = 1'b0;
        e = '0; e.kind = K_DISCONN;
        e.drop_cause = (cmd == C_ERROR) ? CAUSE_XPORT : CAUSE_USER;
        batch.r0 = e; batch.n = 2'd1;
      end
      C_START: begin
        if (!strm_r && open_r) begin
          strm_nxt = 1'b1; ka_nxt = '0;
          if (!req_r) begin
            e = '0; e.kind = K_REQUEST; e.request_bandwidth = bw_r;
            if (alt_r) begin
              e.range_select = wide_r ? 2'd2 : 2'd1;
              wide_nxt = !wide_r;
            end
            batch.r0 = e; batch.n = 2'd1; req_nxt = 1'b1;
          end
        end
      end
      C_STOP: begin
        if (strm_r) begin
          strm_nxt = 1'b0;
          if (open_r) begin
            ka_nxt = '0;
            e = '0; e.kind = K_ECHO; batch.r0 = e; batch.n = 2'd1;
          end
        end
      end
      C_BW, C_RANGE: begin
        if (cmd == C_RANGE || bw_r != bandwidth) begin
          if (cmd == C_BW) bw_nxt = bandwidth;
          if (req_r) stale_nxt = (stale_r < MAXS) ? stale_r + 4'd1 : MAXS;
        end
      end
      C_ALT: begin
        alt_nxt = alt_on; wide_nxt = 1'b0;
        if (alt_on) stale_nxt = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT; fcmd_r <= '0; flen_r <= '0; left_r <= '0;
      open_r <= 1'b0; conn_r <= 1'b0; await_r <= 1'b0; strm_r <= 1'b0;
      req_r <= 1'b0; alt_r <= 1'b0; wide_r <= 1'b0; tv_r <= 1'b0;
      stale_r <= '0; bw_r <= '0; rel_r <= '0; ka_r <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt; fcmd_r <= fcmd_nxt; flen_r <= flen_nxt; left_r <= left_nxt;
      open_r <= open_nxt; conn_r <= conn_nxt; await_r <= await_nxt; strm_r <= strm_nxt;
      req_r <= req_nxt; alt_r <= alt_nxt; wide_r <= wide_nxt; tv_r <= tv_nxt;
      stale_r <= stale_nxt; bw_r <= bw_nxt; rel_r <= rel_nxt; ka_r <= ka_nxt;
    end
  end

endmodule

### rtl/alds_back.sv
module alds_back
  import alds_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  batch_t batch,
  output logic   full,
  alds_out_if.source out_ch
);

  batch_t      q_r [2];
  logic        wp_r, rp_r, sub_r;
  logic [1:0]  cnt_r;
  batch_t      head;
  res_t        cur;
  logic        empty, pop, take;

  assign head  = q_r[rp_r];
  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign cur   = sub_r ? head.r1 : head.r0;
  assign out_ch.valid             = !empty;
  assign out_ch.kind              = cur.kind;
  assign out_ch.data_byte         = cur.data_byte;
  assign out_ch.range_select      = cur.range_select;
  assign out_ch.request_bandwidth = cur.request_bandwidth;
  assign out_ch.drop_cause        = cur.drop_cause;
  assign out_ch.last              = sub_r || (head.n == 2'd1);
  assign take = out_ch.valid && out_ch.ready;
  assign pop  = take && out_ch.last;

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= batch;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; sub_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      if (take) sub_r <= !out_ch.last;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### rtl/alds_checker.sv
module alds_checker
  import alds_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_kind,
  input logic [1:0] out_drop_cause,
  input logic [1:0] out_range_select,
  input logic       out_last
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("valid dropped");
  a_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != K_DISCONN |-> out_drop_cause == 2'd0) else $error("cause");
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_range_select != 2'd3) else $error("range");
  a_disc_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == K_DISCONN |-> out_last) else $error("disconnect not last");
endmodule

bind analyzer_link_deframer_session_unit alds_checker u_chk (
  .clk, .rst_n, .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_kind(out_ch.kind), .out_drop_cause(out_ch.drop_cause),
  .out_range_select(out_ch.range_select), .out_last(out_ch.last)
);

### test/alds_tb_pkg.sv
`timescale 1ns / 1ps
package alds_tb_pkg;
  import alds_pkg::*;

  class session_scoreboard;
    res_t pending_results[$];
    bit   pending_last[$];
    int   mismatches;
    int   results_seen;

    function new();
      mismatches = 0;
      results_seen = 0;
    endfunction

    function void note_result(res_t r, bit lst);
      pending_results.push_back(r);
      pending_last.push_back(lst);
    endfunction

    function void check_result(res_t got, bit got_last);
      res_t exp;
      bit   exp_last;
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result kind=%0d data=%0h", got.kind, got.data_byte);
        return;
      end
      exp = pending_results.pop_front();
      exp_last = pending_last.pop_front();
      if (exp !== got || exp_last !== got_last) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: exp k=%0d d=%0h rs=%0d bw=%0d c=%0d l=%0d",
                    " got k=%0d d=%0h rs=%0d bw=%0d c=%0d l=%0d"},
                   exp.kind, exp.data_byte, exp.range_select, exp.request_bandwidth,
                   exp.drop_cause, exp_last, got.kind, got.data_byte, got.range_select,
                   got.request_bandwidth, got.drop_cause, got_last);
      end
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction
  endclass
endpackage

### test/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import alds_pkg::*;
  import alds_tb_pkg::*;

  localparam int STALE_LIMIT = 8;
  localparam int PH_HUNT = 0, PH_CMD = 1, PH_LEN_LO = 2, PH_LEN_HI = 3, PH_BODY = 4;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #2 clk = ~clk;

  alds_in_if  in_ch();
  alds_out_if out_ch();
  alds_cfg_if cfg_ch();

  analyzer_link_deframer_session_unit DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  session_scoreboard sb = new();

  // predictor copy of the session state
  logic [15:0] p_timeout;
  logic [10:0] p_keepalive;
  int          p_phase;
  logic [7:0]  p_fcmd;
  logic [15:0] p_flen;
  int          p_left;
  bit p_open, p_conn, p_await, p_stream, p_req, p_alt, p_wide, p_tvalid;
  int          p_stale;
  logic [1:0]  p_bw;
  logic [15:0] p_elapsed;
  logic [10:0] p_ka;
  res_t        step_res[2];
  int          step_n;
  int          items_sent;

  function automatic void push_res(logic [2:0] k, logic [7:0] d, logic [1:0] rs,
                                   logic [1:0] bw, logic [1:0] c);
    if (step_n >= 2) return;
    step_res[step_n].kind = k;
    step_res[step_n].data_byte = d;
    step_res[step_n].range_select = rs;
    step_res[step_n].request_bandwidth = bw;
    step_res[step_n].drop_cause = c;
    step_n++;
  endfunction

  function automatic void queue_echo();
    if (!p_stream && p_open) push_res(K_ECHO, 0, 0, 0, 0);
  endfunction

  function automatic void queue_request();
    logic [1:0] rs;
    rs = 0;
    if (!p_open || !p_stream || p_req) return;
    if (p_alt) begin
      rs = p_wide ? 2'd2 : 2'd1;
      p_wide = !p_wide;
    end
    push_res(K_REQUEST, 0, rs, p_bw, 0);
    p_req = 1;
  endfunction

  function automatic void bump_stale();
    if (p_req && p_stale < STALE_LIMIT) p_stale++;
  endfunction

  function automatic void drop_session(logic [1:0] cause, bit clr);
    p_conn = 0; p_await = 0; p_tvalid = 0; p_elapsed = 0;
    p_phase = PH_HUNT; p_left = 0; p_stream = 0; p_req = 0;
    if (clr) p_stale = 0;
    p_ka = 0; p_open = 0;
    push_res(K_DISCONN, 0, 0, 0, cause);
  endfunction

  function automatic void frame_complete();
    if (p_fcmd == FRM_STATUS) return;
    if (p_fcmd == FRM_SPECTRUM) begin
      if (p_flen[2:0] != 0) begin
        push_res(K_BADLEN, 0, 0, 0, 0);
        p_stream = 0; p_req = 0; p_ka = 0;
        queue_echo();
        return;
      end
      p_tvalid = 1; p_elapsed = 0; p_req = 0;
      if (p_stream) begin
        if (p_stale > 0) begin
          p_stale--;
          push_res(K_STALE, 0, 0, 0, 0);
        end else push_res(K_DELIVERED, 0, 0, 0, 0);
        queue_request();
      end else begin
        if (p_stale > 0) p_stale--;
        push_res(K_STALE, 0, 0, 0, 0);
      end
      return;
    end
    p_tvalid = 1; p_elapsed = 0;
    if (p_fcmd == FRM_ECHO && !p_conn) begin
      p_conn = 1; p_await = 0;
      push_res(K_CONNECTED, 0, 0, 0, 0);
    end
  endfunction

  function automatic void predict_byte(logic [7:0] b);
    if (!p_open) return;
    case (p_phase)
      PH_HUNT: if (b == START_BYTE) p_phase = PH_CMD;
      PH_CMD: begin p_fcmd = b; p_phase = PH_LEN_LO; end
      PH_LEN_LO: begin p_flen = {8'h00, b}; p_phase = PH_LEN_HI; end
      PH_LEN_HI: begin
        p_flen[15:8] = b;
        p_left = int'(p_flen) + 2;
        p_phase = PH_BODY;
      end
      default: begin
        if (p_left > 2 && p_fcmd == FRM_SPECTRUM) push_res(K_BYTE, b, 0, 0, 0);
        if (p_left > 0) p_left--;
        if (p_left == 0) begin
          p_phase = PH_HUNT;
          frame_complete();
        end
      end
    endcase
  endfunction

  function automatic void predict_tick();
    if (p_open && p_tvalid) begin
      if (p_elapsed != 16'hFFFF) p_elapsed++;
      if (p_elapsed > p_timeout && (p_conn || p_await)) begin
        drop_session(CAUSE_TIMEOUT, 1);
        return;
      end
    end
    if (p_open && !p_stream) begin
      p_ka = p_ka + 11'd1;
      if (p_ka >= p_keepalive) begin
        p_ka = 0;
        queue_echo();
      end
    end
  endfunction

  // works out the results of one accepted transaction and hands them on
  function automatic void predict_session(logic [3:0] c, logic [7:0] b,
                                          logic [1:0] bw, logic alt);
    step_n = 0;
    case (c)
      C_RX: predict_byte(b);
      C_TICK: predict_tick();
      C_OPEN: if (!p_open) begin
        p_open = 1; p_conn = 0; p_await = 1; p_phase = PH_HUNT; p_left = 0;
        p_tvalid = 1; p_elapsed = 0; p_ka = 0;
        queue_echo();
      end
      C_CLOSE: drop_session(CAUSE_USER, 0);
      C_ERROR: drop_session(CAUSE_XPORT, 1);
      C_START: if (!p_stream && p_open) begin
        p_stream = 1; p_ka = 0;
        queue_request();
      end
      C_STOP: if (p_stream) begin
        p_stream = 0;
        if (p_open) begin
          p_ka = 0;
          queue_echo();
        end
      end
      C_BW: if (p_bw != bw) begin
        p_bw = bw;
        bump_stale();
      end
      C_RANGE: bump_stale();
      C_ALT: begin
        p_alt = alt; p_wide = 0;
        if (alt) p_stale = 0;
      end
      default: ;
    endcase
    for (int i = 0; i < step_n; i++) sb.note_result(step_res[i], i == step_n - 1);
  endfunction

  // one input transaction; idle gap before it drawn per item.
  // valid stays high after acceptance until the next gap or a drain.
  task automatic send_item(logic [3:0] c, logic [7:0] b = 0,
                           logic [1:0] bw = 0, logic alt = 0);
    int gap;
    gap = $urandom_range(0, 4);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= c;
    in_ch.rx_byte <= b;
    in_ch.bandwidth <= bw;
    in_ch.alt_on <= alt;
    do @(posedge clk); while (!in_ch.ready);
    predict_session(c, b, bw, alt);
    items_sent++;
  endtask

  task automatic send_frame(logic [7:0] fc, logic [15:0] len, bit noisy);
    send_item(C_RX, START_BYTE);
    send_item(C_RX, fc);
    send_item(C_RX, len[7:0]);
    send_item(C_RX, len[15:8]);
    for (int i = 0; i < int'(len) + 2; i++) begin
      if (noisy && $urandom_range(0, 9) == 0)
        send_item(logic'($urandom_range(0, 1)) ? C_TICK : C_RANGE);
      send_item(C_RX, 8'($urandom));
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [15:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_TIMEOUT) p_timeout = val;
    else p_keepalive = val[10:0];
    @(posedge clk);
  endtask

  // sink side: random back-pressure, checks every result transaction
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      stall = $urandom_range(0, 4);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      sb.check_result('{out_ch.kind, out_ch.data_byte, out_ch.range_select,
                        out_ch.request_bandwidth, out_ch.drop_cause}, out_ch.last);
    end
  end

  initial begin
    #20_000_000;
    $display("analyzer_link_deframer_session_unit regression: fail");
    $finish;
  end

  initial begin
    int sel;
    in_ch.valid <= 1'b0; in_ch.cmd <= C_RX; in_ch.rx_byte <= 0;
    in_ch.bandwidth <= 0; in_ch.alt_on <= 0;
    cfg_ch.valid <= 1'b0; cfg_ch.index <= REG_TIMEOUT; cfg_ch.data <= 0;
    p_timeout = TIMEOUT_RESET; p_keepalive = KEEPALIVE_RESET;
    p_phase = PH_HUNT; p_fcmd = 0; p_flen = 0; p_left = 0;
    p_open = 0; p_conn = 0; p_await = 0; p_stream = 0; p_req = 0; p_alt = 0;
    p_wide = 0; p_tvalid = 0; p_stale = 0; p_bw = 0; p_elapsed = 0; p_ka = 0;
    items_sent = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: closed-port cases, unknown codes, session bring-up
    send_item(C_RX, START_BYTE);
    send_item(C_CLOSE);
    send_item(C_ERROR);
    send_item(4'd10);
    send_item(4'd15, 8'hFF, 2'd3, 1'b1);
    send_item(C_START);
    send_item(C_OPEN);
    send_item(C_OPEN);
    send_frame(FRM_ECHO, 0, 0);
    send_item(C_ALT, 0, 0, 1'b1);
    send_item(C_BW, 0, 2'd3);
    send_item(C_START);
    send_item(C_START);
    send_item(C_RANGE);
    send_frame(FRM_SPECTRUM, 8, 0);
    send_frame(FRM_SPECTRUM, 3, 0);
    send_frame(FRM_STATUS, 1, 0);
    send_item(C_STOP);
    send_item(C_STOP);
    wait_drained();

    // tight timers: timeout and keep-alive extremes with short counts
    write_reg(REG_TIMEOUT, 16'd3);
    write_reg(REG_KEEPALIVE, 11'd0);
    repeat (6) send_item(C_TICK);
    send_item(C_OPEN);
    repeat (6) send_item(C_TICK);
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin write_reg(REG_TIMEOUT, 16'd40); write_reg(REG_KEEPALIVE, 11'd5); end
        1: begin write_reg(REG_TIMEOUT, 16'hFFFF); write_reg(REG_KEEPALIVE, 11'h7FF); end
        2: begin write_reg(REG_TIMEOUT, 16'd1); write_reg(REG_KEEPALIVE, 11'd1); end
        default: begin
          write_reg(REG_TIMEOUT, 16'd200); write_reg(REG_KEEPALIVE, 11'd50);
        end
      endcase
      repeat (16) begin
        sel = $urandom_range(0, 19);
        if (sel < 8) begin
          if (!p_open) send_item(C_OPEN);
          if ($urandom_range(0, 1)) send_item(C_START);
          send_frame(logic'($urandom_range(0, 3) != 0) ? FRM_SPECTRUM :
                     ($urandom_range(0, 1) ? FRM_ECHO : FRM_STATUS),
                     16'($urandom_range(0, 3) * 8 + ($urandom_range(0, 4) == 0 ? 5 : 0)),
                     1);
        end else if (sel < 10) begin
          send_item(C_RX, 8'($urandom));
        end else if (sel == 10) begin
          send_frame(8'($urandom), 16'($urandom_range(0, 2)), 0);
        end else begin
          send_item(4'($urandom_range(0, 15)), 8'($urandom), 2'($urandom),
                    1'($urandom));
        end
      end
      if (phase == 1) begin
        // one long frame header with large length, then drop it
        send_item(C_OPEN);
        send_item(C_RX, START_BYTE); send_item(C_RX, 8'hFF);
        send_item(C_RX, 8'hFF); send_item(C_RX, 8'hFF);
        send_item(C_ERROR);
      end
      wait_drained();
    end

    $display("Covered %0d input transactions and %0d result transactions", items_sent,
             sb.results_seen);
    $display("over six register settings, mismatches: %0d", sb.mismatches);
    if (sb.mismatches == 0 && sb.outstanding() == 0)
      $display("analyzer_link_deframer_session_unit regression: pass");
    else
      $display("analyzer_link_deframer_session_unit regression: fail");
    $finish;
  end
endmodule

### analyzer_link_deframer_session_unit.f
rtl/alds_pkg.sv
rtl/alds_if.sv
rtl/alds_front.sv
rtl/alds_back.sv
rtl/analyzer_link_deframer_session_unit.sv
rtl/alds_checker.sv
test/alds_tb_pkg.sv
test/testbench.sv
